// File: rtl/obm_pkg.sv
package obm_pkg;

  // Default sizing of the order stores and value fields.
  localparam int SIDE_DEPTH_DEF = 16;
  localparam int VALUE_BITS_DEF = 40;

  // Field widths fixed by the order format.
  localparam int ID_BITS   = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_PRODUCT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TIME    = 1'd1;

  // Most sales reported for one order set.
  localparam int MAX_RESULTS = 32;
  localparam int SALE_W      = $clog2(MAX_RESULTS + 1);

  // Order side codes.
  localparam logic SIDE_ASK = 1'b0;
  localparam logic SIDE_BID = 1'b1;

endpackage

// File: rtl/obm_store.sv
module obm_store import obm_pkg::*; #(
  parameter int DEPTH = SIDE_DEPTH_DEF,
  parameter int WIDTH = 2 * VALUE_BITS_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [IDX_W-1:0] ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// File: rtl/order_book_ask_bid_matcher.sv
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   side, product_id, time_id, order_price,
//                                         order_amount, last_order
// out      source     out_valid/out_stall sale_valid, sale_price, sale_amount,
//                                         dropped_orders, last_sale
// cfg      sink       cfg_we              cfg_index, cfg_data
//
// A kept order into a nonempty store is placed by a sorted insertion walk over the side
// store (S_INS, then S_PUT at the bottom); any other order is taken in S_IDLE.
// Matching reads each ask (S_ASK, S_ASKD) and walks the bids for it (S_BID, S_BIDD),
// then closes the run in S_END; every sale is held back until the next is known, to mark
// the last one, and a stalled result adds its stall cycles to the run.
// Reset (rst, synchronous) empties both stores and clears the drop flag; the
// stores need no clearing pass. in_stall is high while an accepted order is being
// inserted or a run of results is issued; out_stall holds the result register.
module order_book_ask_bid_matcher import obm_pkg::*; #(
  parameter int SIDE_DEPTH = SIDE_DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ID_BITS-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  side,
  input  logic [ID_BITS-1:0]    product_id,
  input  logic [ID_BITS-1:0]    time_id,
  input  logic [VALUE_BITS-1:0] order_price,
  input  logic [VALUE_BITS-1:0] order_amount,
  input  logic                  last_order,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  sale_valid,
  output logic [VALUE_BITS-1:0] sale_price,
  output logic [VALUE_BITS-1:0] sale_amount,
  output logic                  dropped_orders,
  output logic                  last_sale
);

  localparam int IDX_W = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
  localparam int CNT_W = $clog2(SIDE_DEPTH + 1);
  localparam int ENT_W = 2 * VALUE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_ASK  = 3'd3;
  localparam logic [2:0] S_ASKD = 3'd4;
  localparam logic [2:0] S_BID  = 3'd5;
  localparam logic [2:0] S_BIDD = 3'd6;
  localparam logic [2:0] S_END  = 3'd7;

  logic [2:0]            state, state_next;
  logic [ID_BITS-1:0]    match_product, match_time;
  logic                  side_q, side_q_next;
  logic                  last_q, last_q_next;
  logic [VALUE_BITS-1:0] price_q, price_q_next, amt_q, amt_q_next;
  logic [CNT_W-1:0]      pos, pos_next, pos_inc;
  logic [CNT_W-1:0]      ask_count, ask_count_next, bid_count, bid_count_next;
  logic [CNT_W-1:0]      a_idx, a_idx_next, b_idx, b_idx_next, in_cnt;
  logic                  overflow, overflow_next;
  logic [VALUE_BITS-1:0] ap, ap_next, aa, aa_next;
  logic                  pend_valid, pend_valid_next;
  logic [VALUE_BITS-1:0] pend_price, pend_price_next, pend_amt, pend_amt_next;
  logic [SALE_W-1:0]     sales, sales_next;
  logic                  keep, after, out_free, done_last;

  // Store ports, insertion side and match side.
  logic             ins_side, ins_we, ins_re;
  logic [IDX_W-1:0] ins_wa, ins_ra;
  logic [ENT_W-1:0] ins_wd;
  logic             m_ask_re, m_bid_re, m_bid_we;
  logic [IDX_W-1:0] m_ask_ra, m_bid_ra, m_bid_wa;
  logic [ENT_W-1:0] m_bid_wd;
  logic             ask_we, ask_re, bid_we, bid_re;
  logic [IDX_W-1:0] ask_wa, ask_ra, bid_wa, bid_ra;
  logic [ENT_W-1:0] ask_wd, bid_wd, ask_rd, bid_rd, ins_rd;
  logic [VALUE_BITS-1:0] rd_price, bid_p, bid_a;

  // Result register load.
  logic                  emit, e_valid, e_last;
  logic [VALUE_BITS-1:0] e_price, e_amount;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign keep      = (product_id == match_product) && (time_id == match_time);
  assign in_cnt    = side ? bid_count : ask_count;
  assign pos_inc   = pos + CNT_W'(1);
  assign ins_rd    = side_q ? bid_rd : ask_rd;
  assign rd_price  = ins_rd[ENT_W-1:VALUE_BITS];
  assign after     = side_q ? (rd_price < price_q) : (rd_price > price_q);
  assign done_last = last_q;
  assign bid_p     = bid_rd[ENT_W-1:VALUE_BITS];
  assign bid_a     = bid_rd[VALUE_BITS-1:0];

  // Route the two users of the stores to their ports.
  assign ask_we = ins_we && (ins_side == SIDE_ASK);
  assign ask_wa = ins_wa;
  assign ask_wd = ins_wd;
  assign ask_re = (ins_re && (ins_side == SIDE_ASK)) || m_ask_re;
  assign ask_ra = m_ask_re ? m_ask_ra : ins_ra;
  assign bid_we = (ins_we && (ins_side == SIDE_BID)) || m_bid_we;
  assign bid_wa = m_bid_we ? m_bid_wa : ins_wa;
  assign bid_wd = m_bid_we ? m_bid_wd : ins_wd;
  assign bid_re = (ins_re && (ins_side == SIDE_BID)) || m_bid_re;
  assign bid_ra = m_bid_re ? m_bid_ra : ins_ra;

  obm_store #(.DEPTH(SIDE_DEPTH), .WIDTH(ENT_W)) u_ask (
    .clk(clk), .we(ask_we), .wa(ask_wa), .wd(ask_wd),
    .re(ask_re), .ra(ask_ra), .rd(ask_rd)
  );

  obm_store #(.DEPTH(SIDE_DEPTH), .WIDTH(ENT_W)) u_bid (
    .clk(clk), .we(bid_we), .wa(bid_wa), .wd(bid_wd),
    .re(bid_re), .ra(bid_ra), .rd(bid_rd)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_product <= '0;
      match_time    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_PRODUCT: match_product <= cfg_data;
        REG_MATCH_TIME:    match_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: sorted insertion on load, then the ask/bid walk.
  always_comb begin
    state_next      = state;
    side_q_next     = side_q;
    last_q_next     = last_q;
    price_q_next    = price_q;
    amt_q_next      = amt_q;
    pos_next        = pos;
    ask_count_next  = ask_count;
    bid_count_next  = bid_count;
    a_idx_next      = a_idx;
    b_idx_next      = b_idx;
    overflow_next   = overflow;
    ap_next         = ap;
    aa_next         = aa;
    pend_valid_next = pend_valid;
    pend_price_next = pend_price;
    pend_amt_next   = pend_amt;
    sales_next      = sales;
    ins_side        = side_q;
    ins_we          = 1'b0;
    ins_wa          = '0;
    ins_wd          = {price_q, amt_q};
    ins_re          = 1'b0;
    ins_ra          = '0;
    m_ask_re        = 1'b0;
    m_ask_ra        = a_idx[IDX_W-1:0];
    m_bid_re        = 1'b0;
    m_bid_ra        = b_idx[IDX_W-1:0];
    m_bid_we        = 1'b0;
    m_bid_wa        = b_idx[IDX_W-1:0];
    m_bid_wd        = {bid_p, bid_a};
    emit            = 1'b0;
    e_valid         = 1'b0;
    e_price         = '0;
    e_amount        = '0;
    e_last          = 1'b0;
    unique case (state)
      S_IDLE: begin
        a_idx_next = '0;
        sales_next = '0;
        if (in_valid) begin
          side_q_next  = side;
          last_q_next  = last_order;
          price_q_next = order_price;
          amt_q_next   = order_amount;
          ins_side     = side;
          ins_wd       = {order_price, order_amount};
          state_next   = last_order ? S_ASK : S_IDLE;
          if (keep && (in_cnt == CNT_W'(SIDE_DEPTH))) begin
            overflow_next = 1'b1;
          end else if (keep && (in_cnt == '0)) begin
            ins_we = 1'b1;
            if (side) begin
              bid_count_next = bid_count + CNT_W'(1);
            end else begin
              ask_count_next = ask_count + CNT_W'(1);
            end
          end else if (keep) begin
            ins_re     = 1'b1;
            pos_next   = in_cnt - CNT_W'(1);
            ins_ra     = pos_next[IDX_W-1:0];
            state_next = S_INS;
          end
        end
      end
      S_INS: begin
        ins_we = 1'b1;
        ins_wa = pos_inc[IDX_W-1:0];
        if (after) begin
          // Move the entry that sorts after the new one up one place and look further down.
          ins_wd = ins_rd;
          if (pos == '0) begin
            state_next = S_PUT;
          end else begin
            ins_re   = 1'b1;
            pos_next = pos - CNT_W'(1);
            ins_ra   = pos_next[IDX_W-1:0];
          end
        end else begin
          if (side_q) begin
            bid_count_next = bid_count + CNT_W'(1);
          end else begin
            ask_count_next = ask_count + CNT_W'(1);
          end
          state_next = done_last ? S_ASK : S_IDLE;
        end
      end
      S_PUT: begin
        ins_we = 1'b1;
        if (side_q) begin
          bid_count_next = bid_count + CNT_W'(1);
        end else begin
          ask_count_next = ask_count + CNT_W'(1);
        end
        state_next = done_last ? S_ASK : S_IDLE;
      end
      S_ASK: begin
        if ((a_idx >= ask_count) || (sales == SALE_W'(MAX_RESULTS))) begin
          state_next = S_END;
        end else begin
          m_ask_re   = 1'b1;
          state_next = S_ASKD;
        end
      end
      S_ASKD: begin
        ap_next    = ask_rd[ENT_W-1:VALUE_BITS];
        aa_next    = ask_rd[VALUE_BITS-1:0];
        b_idx_next = '0;
        state_next = S_BID;
      end
      S_BID: begin
        if ((aa == '0) || (b_idx >= bid_count) || (sales == SALE_W'(MAX_RESULTS))) begin
          a_idx_next = a_idx + CNT_W'(1);
          state_next = S_ASK;
        end else begin
          m_bid_re   = 1'b1;
          state_next = S_BIDD;
        end
      end
      S_BIDD: begin
        if ((bid_a == '0) || (bid_p < ap)) begin
          b_idx_next = b_idx + CNT_W'(1);
          state_next = S_BID;
        end else if (!pend_valid || out_free) begin
          // Issue the held sale and hold this one until the next is known.
          emit            = pend_valid;
          e_valid         = 1'b1;
          e_price         = pend_price;
          e_amount        = pend_amt;
          pend_valid_next = 1'b1;
          pend_price_next = ap;
          sales_next      = sales + SALE_W'(1);
          m_bid_we        = 1'b1;
          state_next      = S_BID;
          if (bid_a >= aa) begin
            pend_amt_next = aa;
            m_bid_wd      = {bid_p, bid_a - aa};
            aa_next       = '0;
          end else begin
            pend_amt_next = bid_a;
            m_bid_wd      = {bid_p, {VALUE_BITS{1'b0}}};
            aa_next       = aa - bid_a;
            b_idx_next    = b_idx + CNT_W'(1);
          end
        end
      end
      S_END: begin
        if (out_free) begin
          emit            = 1'b1;
          e_valid         = pend_valid;
          e_price         = pend_valid ? pend_price : '0;
          e_amount        = pend_valid ? pend_amt : '0;
          e_last          = 1'b1;
          pend_valid_next = 1'b0;
          ask_count_next  = '0;
          bid_count_next  = '0;
          overflow_next   = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ask_count  <= '0;
      bid_count  <= '0;
      overflow   <= 1'b0;
      pend_valid <= 1'b0;
      sales      <= '0;
      a_idx      <= '0;
      b_idx      <= '0;
      pos        <= '0;
    end else begin
      state      <= state_next;
      ask_count  <= ask_count_next;
      bid_count  <= bid_count_next;
      overflow   <= overflow_next;
      pend_valid <= pend_valid_next;
      sales      <= sales_next;
      a_idx      <= a_idx_next;
      b_idx      <= b_idx_next;
      pos        <= pos_next;
    end
  end

  // Working payload.
  always_ff @(posedge clk) begin
    side_q     <= side_q_next;
    last_q     <= last_q_next;
    price_q    <= price_q_next;
    amt_q      <= amt_q_next;
    ap         <= ap_next;
    aa         <= aa_next;
    pend_price <= pend_price_next;
    pend_amt   <= pend_amt_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sale_valid     <= e_valid;
      sale_price     <= e_price;
      sale_amount    <= e_amount;
      dropped_orders <= overflow;
      last_sale      <= e_last;
    end
  end

endmodule

// File: rtl/obm_checker.sv
module obm_checker import obm_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  sale_valid,
  input logic [VALUE_BITS-1:0] sale_price,
  input logic [VALUE_BITS-1:0] sale_amount,
  input logic                  last_sale
);

  // A result waiting on a stall stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sale_price) && $stable(sale_amount))
    else $error("stalled result changed");

  // The no-sale result ends its run and carries zero values.
  a_nosale: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sale_valid |-> last_sale && (sale_price == '0) && (sale_amount == '0))
    else $error("bad no-sale result");

  // Emptied entries are skipped, so no sale moves a zero amount.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && sale_valid |-> (sale_amount != '0))
    else $error("sale of zero amount");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind order_book_ask_bid_matcher obm_checker #(.VALUE_BITS(VALUE_BITS)) u_obm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .sale_valid(sale_valid), .sale_price(sale_price), .sale_amount(sale_amount),
  .last_sale(last_sale)
);

// File: test/tb_order_book_ask_bid_matcher.sv
`timescale 1ns / 1ps

module tb_order_book_ask_bid_matcher;
  import obm_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int DEPTH = SIDE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [VB-1:0] value_t;

  typedef struct packed {
    logic   sale_valid;
    value_t sale_price;
    value_t sale_amount;
    logic   dropped_orders;
    logic   last_sale;
  } sale_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MATCH_PRODUCT;
  logic [ID_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic side = SIDE_ASK;
  logic [ID_BITS-1:0] product_id = '0;
  logic [ID_BITS-1:0] time_id = '0;
  value_t order_price = '0;
  value_t order_amount = '0;
  logic last_order = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic sale_valid;
  value_t sale_price;
  value_t sale_amount;
  logic dropped_orders;
  logic last_sale;

  order_book_ask_bid_matcher u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow order book used to predict the sales.
  logic [ID_BITS-1:0] book_product = '0;
  logic [ID_BITS-1:0] book_time = '0;
  value_t ask_px[DEPTH];
  value_t ask_qty[DEPTH];
  value_t bid_px[DEPTH];
  value_t bid_qty[DEPTH];
  int ask_n = 0;
  int bid_n = 0;
  logic book_overflow = 1'b0;
  sale_t pending_sales[$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_output = 1'b0;
  int quiet_cycles = 0;

  // Sorted insertion; asks ascend, bids descend, ties keep arrival order.
  task automatic book_insert(input logic is_bid, input value_t px, input value_t qty);
    int pos;
    int n;
    n = is_bid ? bid_n : ask_n;
    if (n >= DEPTH) begin
      book_overflow = 1'b1;
      return;
    end
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (is_bid ? (bid_px[i] < px) : (ask_px[i] > px)) begin
        pos = i;
        break;
      end
    end
    for (int i = n; i > pos; i--) begin
      if (is_bid) begin
        bid_px[i] = bid_px[i-1];
        bid_qty[i] = bid_qty[i-1];
      end else begin
        ask_px[i] = ask_px[i-1];
        ask_qty[i] = ask_qty[i-1];
      end
    end
    if (is_bid) begin
      bid_px[pos] = px;
      bid_qty[pos] = qty;
      bid_n++;
    end else begin
      ask_px[pos] = px;
      ask_qty[pos] = qty;
      ask_n++;
    end
  endtask

  // Append one expected sale to the tail of the queue.
  task automatic queue_sale(input sale_t s);
    pending_sales = {pending_sales, s};
  endtask

  // Match the book and queue the resulting sales, then empty the book.
  task automatic match_book();
    int made;
    value_t left;
    sale_t s;
    made = 0;
    for (int a = 0; a < ask_n; a++) begin
      left = ask_qty[a];
      for (int b = 0; b < bid_n; b++) begin
        if (left == 0 || made >= MAX_RESULTS) break;
        if (bid_qty[b] == 0 || bid_px[b] < ask_px[a]) continue;
        s = '{1'b1, ask_px[a], '0, book_overflow, 1'b0};
        if (bid_qty[b] >= left) begin
          s.sale_amount = left;
          bid_qty[b] -= left;
          left = 0;
          queue_sale(s);
          made++;
          break;
        end
        s.sale_amount = bid_qty[b];
        left -= bid_qty[b];
        bid_qty[b] = 0;
        queue_sale(s);
        made++;
      end
      ask_qty[a] = left;
    end
    if (made == 0) begin
      s = '{1'b0, '0, '0, book_overflow, 1'b1};
      queue_sale(s);
    end else begin
      s = pending_sales.pop_back();
      s.last_sale = 1'b1;
      queue_sale(s);
    end
    ask_n = 0;
    bid_n = 0;
    book_overflow = 1'b0;
  endtask

  // Present one order and wait for the transaction to be accepted.
  task automatic send_order(input logic s, input logic [ID_BITS-1:0] p,
                            input logic [ID_BITS-1:0] t, input value_t px,
                            input value_t qty, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    side <= s;
    product_id <= p;
    time_id <= t;
    order_price <= px;
    order_amount <= qty;
    last_order <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (p == book_product && t == book_time) book_insert(s, px, qty);
    if (last) match_book();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_sales.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MATCH_PRODUCT) book_product = val;
    else if (idx == REG_MATCH_TIME) book_time = val;
    @(posedge clk);
  endtask

  function automatic value_t rand_value();
    case ($urandom_range(3))
      0: return value_t'({$urandom, $urandom});
      1: return value_t'($urandom_range(20));
      default: return value_t'($urandom_range(1000)) << 20;
    endcase
  endfunction

  // Random order of the current product and slot, with some foreign noise.
  task automatic send_random_order(input logic last);
    logic [ID_BITS-1:0] p;
    logic [ID_BITS-1:0] t;
    p = book_product;
    t = book_time;
    if ($urandom_range(9) == 0) begin
      p = ID_BITS'($urandom);
      t = ID_BITS'($urandom);
    end else if ($urandom_range(19) == 0) begin
      p = book_product ^ (16'h1 << $urandom_range(15));
    end
    send_order(1'($urandom_range(1)), p, t, rand_value(), rand_value(), last);
  endtask

  task automatic test_directed();
    value_t big;
    big = {VB{1'b1}};
    write_reg(REG_MATCH_PRODUCT, 16'hFFFF);
    write_reg(REG_MATCH_TIME, 16'hFFFF);
    // A lone filtered order that ends the set: one no-sale result.
    send_order(SIDE_BID, 16'h0000, 16'h0000, big, big, 1'b1);
    // Equal amounts, then a larger bid, then a smaller bid continuing the walk.
    send_order(SIDE_ASK, 16'hFFFF, 16'hFFFF, 40'd100, 40'd50, 1'b0);
    send_order(SIDE_BID, 16'hFFFF, 16'hFFFF, 40'd100, 40'd50, 1'b0);
    send_order(SIDE_ASK, 16'hFFFF, 16'hFFFF, 40'd200, 40'd10, 1'b0);
    send_order(SIDE_BID, 16'hFFFF, 16'hFFFF, big, 40'd30, 1'b0);
    send_order(SIDE_ASK, 16'hFFFF, 16'hFFFF, 40'd0, 40'd0, 1'b0);
    send_order(SIDE_BID, 16'hFFFF, 16'hFFFF, 40'd300, 40'd5, 1'b0);
    send_order(SIDE_ASK, 16'hFFFF, 16'hFFFF, 40'd250, big, 1'b0);
    send_order(SIDE_BID, 16'h1234, 16'hFFFF, big, big, 1'b1);
    // Bids below every ask: no sale.
    send_order(SIDE_ASK, 16'hFFFF, 16'hFFFF, big, 40'd1, 1'b0);
    send_order(SIDE_BID, 16'hFFFF, 16'hFFFF, 40'd0, big, 1'b1);
    wait_drained();
    write_reg(REG_MATCH_PRODUCT, 16'h0000);
    write_reg(REG_MATCH_TIME, 16'h0000);
    // Overfill the bid store so that orders are dropped.
    for (int i = 0; i < DEPTH + 3; i++)
      send_order(SIDE_BID, 16'h0, 16'h0, value_t'(i), 40'd1, 1'b0);
    send_order(SIDE_ASK, 16'h0, 16'h0, 40'd1, 40'd100, 1'b1);
    wait_drained();
  endtask

  // Full stores of crossing orders for a long run of sales.
  task automatic test_result_limit();
    for (int i = 0; i < DEPTH; i++)
      send_order(SIDE_BID, book_product, book_time, 40'd1000, 40'd1, 1'b0);
    for (int i = 0; i < DEPTH; i++)
      send_order(SIDE_ASK, book_product, book_time, value_t'(i), 40'd3, i == DEPTH - 1);
    wait_drained();
  endtask

  task automatic test_random_sets(input int orders, input int sidle, input int ridle);
    int sent;
    int set_len;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < orders) begin
      set_len = $urandom_range(1, ($urandom_range(4) == 0) ? 36 : 10);
      for (int i = 0; i < set_len; i++) send_random_order(i == set_len - 1);
      sent += set_len;
    end
    wait_drained();
  endtask

  // Hold the output long enough for the block to stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_output = 1'b1;
    for (int i = 0; i < 12; i++) send_random_order(i % 3 == 2);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_result_limit();
    write_reg(REG_MATCH_PRODUCT, 16'h5A5A);
    write_reg(REG_MATCH_TIME, 16'h00C3);
    test_random_sets(110, 17, 66);
    write_reg(REG_MATCH_PRODUCT, ID_BITS'($urandom));
    write_reg(REG_MATCH_TIME, ID_BITS'($urandom));
    test_random_sets(110, 66, 17);
    test_backpressure();
    test_random_sets(110, 0, 0);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver stall, with a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_output) begin
      out_stall <= 1'b1;
      repeat (300) @(posedge clk);
      hold_output = 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected sale.
  always @(posedge clk) begin
    sale_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sales.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        want = pending_sales.pop_front();
        if (sale_valid !== want.sale_valid) begin
          $error("sale_valid expected %0d got %0d", want.sale_valid, sale_valid);
          fail_count++;
        end
        if (sale_price !== want.sale_price) begin
          $error("sale_price expected %0h got %0h", want.sale_price, sale_price);
          fail_count++;
        end
        if (sale_amount !== want.sale_amount) begin
          $error("sale_amount expected %0h got %0h", want.sale_amount, sale_amount);
          fail_count++;
        end
        if (dropped_orders !== want.dropped_orders) begin
          $error("dropped_orders expected %0d got %0d", want.dropped_orders,
                 dropped_orders);
          fail_count++;
        end
        if (last_sale !== want.last_sale) begin
          $error("last_sale expected %0d got %0d", want.last_sale, last_sale);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
